// ===== rtl/segment_lcd_serial_writer_defines.svh =====
// Assertion macros shared by the segment LCD serial writer RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SEGMENT_LCD_SERIAL_WRITER_DEFINES_SVH
`define SEGMENT_LCD_SERIAL_WRITER_DEFINES_SVH

// Plain invariant, checked at every clock edge out of reset
`define SLW_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("slw invariant failed");

// Same-cycle implication
`define SLW_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slw implication failed");

// Next-cycle implication
`define SLW_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slw next-cycle check failed");

`endif

// ===== rtl/slw_pkg.sv =====
// Package for the segment LCD serial writer: opcodes, sequencer states,
// decoded item type and the segment tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slw_pkg;

  localparam int BITS_W   = 9;   // payload bit count, up to 511
  localparam int SEG_W    = 64;  // eight segment bytes
  localparam int HDR_W    = 12;
  localparam int Q_DEPTH  = 2;
  localparam int Q_CNT_W  = 2;

  localparam int PIN_CS = 2;
  localparam int PIN_WR = 1;
  localparam int PIN_DA = 0;
  localparam logic [2:0] PINS_IDLE = 3'b111;

  localparam logic [2:0] ID_CMD   = 3'b100;
  localparam logic [2:0] ID_WRITE = 3'b101;
  localparam logic [3:0] CMD_HDR_BITS   = 4'd12;
  localparam logic [3:0] WRITE_HDR_BITS = 4'd9;

  localparam logic [7:0] TOP_POINT  = 8'h80;
  localparam logic [7:0] BOT_POINT  = 8'h08;
  localparam logic [7:0] UNIT_MARK  = 8'h80;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CMD   = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ADDR  = 2'd0,
    REG_LEAD  = 2'd1,
    REG_PHASE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEAD = 3'd1,
    PH_LOW  = 3'd2,
    PH_HIGH = 3'd3,
    PH_TAIL = 3'd4
  } phase_t;

  typedef struct packed {
    op_t               op;
    logic [HDR_W-1:0]  hdr_shift;
    logic [3:0]        hdr_left;
    logic [BITS_W-1:0] bits_left;
    logic [SEG_W-1:0]  seg;
  } dec_t;

  typedef struct packed {
    logic select_line;
    logic strobe_line;
    logic data_line;
    logic busy;
    logic rejected;
    logic frame_done;
  } res_t;

  // Top row glyphs; unknown codes show blank
  function automatic logic [7:0] top_seg(input logic [4:0] code);
    logic [7:0] s;
    unique case (code)
      5'd0:    s = 8'h5F;
      5'd1:    s = 8'h50;
      5'd2:    s = 8'h3D;
      5'd3:    s = 8'h79;
      5'd4:    s = 8'h72;
      5'd5:    s = 8'h6B;
      5'd6:    s = 8'h6F;
      5'd7:    s = 8'h51;
      5'd8:    s = 8'h7F;
      5'd9:    s = 8'h7B;
      5'd10:   s = 8'h20;
      5'd12:   s = 8'h77;
      5'd13:   s = 8'h27;
      5'd14:   s = 8'h64;
      5'd15:   s = 8'h6C;
      5'd16:   s = 8'h26;
      5'd17:   s = 8'h4C;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Bottom row glyphs, segments wired in a different order
  function automatic logic [7:0] bot_seg(input logic [4:0] code);
    logic [7:0] s;
    unique case (code)
      5'd0:    s = 8'hF5;
      5'd1:    s = 8'h05;
      5'd2:    s = 8'hB6;
      5'd3:    s = 8'h97;
      5'd4:    s = 8'h47;
      5'd5:    s = 8'hD3;
      5'd6:    s = 8'hF3;
      5'd7:    s = 8'h85;
      5'd8:    s = 8'hF7;
      5'd9:    s = 8'hD7;
      5'd10:   s = 8'h02;
      5'd12:   s = 8'hE7;
      5'd13:   s = 8'hE2;
      5'd14:   s = 8'h23;
      5'd15:   s = 8'h33;
      5'd16:   s = 8'h62;
      5'd17:   s = 8'h31;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/slw_front.sv =====
// Front end: turns an incoming item into a ready-to-run frame description
// (header bits, payload count, segment image). Depends on slw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slw_front
  import slw_pkg::*;
#(
  parameter int SEGMENT_BYTES = 8,
  parameter int CLEAR_BITS    = 128
) (
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_command_byte,
  input  wire logic [19:0] in_top_digits,
  input  wire logic [19:0] in_bottom_digits,
  input  wire logic [1:0]  in_decimal_points,
  input  wire logic [1:0]  in_unit_marks,
  input  wire logic [5:0]  display_address,
  output dec_t             dec
);

  localparam int WRITE_BITS = 8 * SEGMENT_BYTES;

  logic [7:0] seg_byte [8];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      seg_byte[i]     = top_seg(in_top_digits[15-5*i +: 5]);
      seg_byte[7 - i] = bot_seg(in_bottom_digits[15-5*i +: 5]);
    end
    if (in_decimal_points[0]) seg_byte[2] = seg_byte[2] | TOP_POINT;
    if (in_decimal_points[1]) seg_byte[5] = seg_byte[5] | BOT_POINT;
    if (in_unit_marks[0])     seg_byte[3] = seg_byte[3] | UNIT_MARK;
    if (in_unit_marks[1])     seg_byte[1] = seg_byte[1] | UNIT_MARK;
  end

  always_comb begin
    dec.op        = op_t'(in_opcode);
    dec.hdr_shift = '0;
    dec.hdr_left  = '0;
    dec.bits_left = '0;
    dec.seg       = '0;
    unique case (op_t'(in_opcode))
      OP_CMD: begin
        dec.hdr_shift = {ID_CMD, in_command_byte, 1'b0};
        dec.hdr_left  = CMD_HDR_BITS;
      end
      OP_WRITE: begin
        dec.hdr_shift = {ID_WRITE, display_address, 3'b000};
        dec.hdr_left  = WRITE_HDR_BITS;
        dec.bits_left = BITS_W'(WRITE_BITS);
        for (int i = 0; i < 8; i++) dec.seg[8*i +: 8] = seg_byte[i];
      end
      OP_CLEAR: begin
        dec.hdr_shift = {ID_WRITE, 6'd0, 3'b000};
        dec.hdr_left  = WRITE_HDR_BITS;
        dec.bits_left = BITS_W'(CLEAR_BITS);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/slw_queue.sv =====
// Two-entry queue of decoded items between the front end and the sequencer.
// Depends on slw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_lcd_serial_writer_defines.svh"

module slw_queue
  import slw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire dec_t push_data,
  output logic      push_ready,
  output logic      pop_valid,
  input  wire logic pop,
  output dec_t      pop_data
);

  dec_t               mem_r [Q_DEPTH];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign push_ready = count_r != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SLW_ASSERT(a_q_bound, count_r <= Q_CNT_W'(Q_DEPTH))
  `SLW_IMPLY(a_q_no_underflow, pop, count_r != '0)
  `SLW_NEXT(a_q_pass_through, push && pop, count_r == $past(count_r))

endmodule

`default_nettype wire

// ===== rtl/slw_back.sv =====
// Frame sequencer: runs one queued item per cycle, unless a result is stalled,
// on the pin state machine and registers the result. Depends on slw_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_lcd_serial_writer_defines.svh"

module slw_back
  import slw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] lead_ticks,
  input  wire logic [7:0] phase_ticks,
  input  wire logic       q_valid,
  input  wire dec_t       q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output res_t            out_res
);

  phase_t            phase_r, phase_nxt;
  logic [HDR_W-1:0]  hdr_shift_r, hdr_shift_nxt;
  logic [3:0]        hdr_left_r, hdr_left_nxt;
  logic [BITS_W-1:0] bits_left_r, bits_left_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [7:0]        tick_r, tick_nxt;
  logic [2:0]        pins_r, pins_nxt;
  logic              out_valid_r;
  res_t              res_r, res_nxt;

  logic is_req, idle, over, need_bit, start_bit, bit_val;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign is_req    = q_data.op != OP_TICK;
  assign idle      = phase_r == PH_IDLE;
  assign over      = tick_r <= 8'd1;
  assign need_bit  = (hdr_left_r != '0) || (bits_left_r != '0);
  assign start_bit = q_pop && !is_req && over &&
                     ((phase_r == PH_LEAD) || ((phase_r == PH_HIGH) && need_bit));
  assign bit_val   = (hdr_left_r != '0) ? hdr_shift_r[HDR_W-1] : seg_r[0];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      if (is_req) begin
        if (idle) phase_nxt = PH_LEAD;
      end else begin
        unique case (phase_r)
          PH_IDLE: phase_nxt = PH_IDLE;
          PH_LEAD: if (over) phase_nxt = PH_LOW;
          PH_LOW:  if (over) phase_nxt = PH_HIGH;
          PH_HIGH: if (over) phase_nxt = need_bit ? PH_LOW : PH_TAIL;
          PH_TAIL: if (over) phase_nxt = PH_IDLE;
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    hdr_shift_nxt = hdr_shift_r;
    hdr_left_nxt  = hdr_left_r;
    bits_left_nxt = bits_left_r;
    seg_nxt       = seg_r;
    tick_nxt      = tick_r;
    pins_nxt      = pins_r;
    res_nxt       = '0;
    if (q_pop) begin
      if (is_req) begin
        if (idle) begin
          hdr_shift_nxt    = q_data.hdr_shift;
          hdr_left_nxt     = q_data.hdr_left;
          bits_left_nxt    = q_data.bits_left;
          seg_nxt          = q_data.seg;
          pins_nxt[PIN_CS] = 1'b0;
          tick_nxt         = lead_ticks;
        end else begin
          res_nxt.rejected = 1'b1;
        end
      end else if (!idle) begin
        tick_nxt = over ? 8'd0 : tick_r - 8'd1;
        if (start_bit) begin
          if (hdr_left_r != '0) begin
            hdr_shift_nxt = {hdr_shift_r[HDR_W-2:0], 1'b0};
            hdr_left_nxt  = hdr_left_r - 4'd1;
          end else begin
            seg_nxt = {1'b0, seg_r[SEG_W-1:1]};
            if (bits_left_r != '0) bits_left_nxt = bits_left_r - BITS_W'(1);
          end
          pins_nxt[PIN_WR] = 1'b0;
          pins_nxt[PIN_DA] = bit_val;
          tick_nxt         = phase_ticks;
        end
        if ((phase_r == PH_LOW) && over) begin
          pins_nxt[PIN_WR] = 1'b1;
          tick_nxt         = phase_ticks;
        end
        if ((phase_r == PH_HIGH) && over && !need_bit) begin
          pins_nxt[PIN_CS] = 1'b1;
          tick_nxt         = lead_ticks;
        end
        if ((phase_r == PH_TAIL) && over) begin
          pins_nxt[PIN_DA]   = 1'b1;
          res_nxt.frame_done = 1'b1;
        end
      end
    end
    res_nxt.select_line = pins_nxt[PIN_CS];
    res_nxt.strobe_line = pins_nxt[PIN_WR];
    res_nxt.data_line   = pins_nxt[PIN_DA];
    res_nxt.busy        = phase_nxt != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_shift_r <= '0;
      hdr_left_r  <= '0;
      bits_left_r <= '0;
      seg_r       <= '0;
      tick_r      <= '0;
      pins_r      <= PINS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_shift_r <= hdr_shift_nxt;
      hdr_left_r  <= hdr_left_nxt;
      bits_left_r <= bits_left_nxt;
      seg_r       <= seg_nxt;
      tick_r      <= tick_nxt;
      pins_r      <= pins_nxt;
      if (q_pop)          out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `SLW_IMPLY(a_idle_pins_high, phase_r == PH_IDLE, pins_r == PINS_IDLE)
  `SLW_IMPLY(a_select_in_frame,
             phase_r == PH_LEAD || phase_r == PH_LOW || phase_r == PH_HIGH,
             !pins_r[PIN_CS])
  `SLW_IMPLY(a_strobe_low_phase, phase_r == PH_LOW, !pins_r[PIN_WR])
  `SLW_NEXT(a_reject_reported, q_pop && is_req && !idle,
            out_valid_r && res_r.rejected && res_r.busy)

endmodule

`default_nettype wire

// ===== rtl/segment_lcd_serial_writer.sv =====
// Segment LCD serial writer: takes one item per clock while the queue has room
// and returns one result per item. Each item passes a combinational decode
// (segment tables, header build), a two-entry queue and a sequencer step into
// an output register; throughput is one item per cycle while results are
// taken, set by the single sequencer update each item makes. Pin timing is
// counted in tick items, not clocks.
// Depends on slw_pkg, slw_front, slw_queue and slw_back.
`timescale 1ns / 1ps
`default_nettype none

module segment_lcd_serial_writer
  import slw_pkg::*;
#(
  parameter int SEGMENT_BYTES = 8,
  parameter int CLEAR_BITS    = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_command_byte,
  input  wire logic [19:0] in_top_digits,
  input  wire logic [19:0] in_bottom_digits,
  input  wire logic [1:0]  in_decimal_points,
  input  wire logic [1:0]  in_unit_marks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_select_line,
  output logic             out_strobe_line,
  output logic             out_data_line,
  output logic             out_busy_res,
  output logic             out_rejected,
  output logic             out_frame_done,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [5:0] disp_addr_r;
  logic [7:0] lead_ticks_r;
  logic [7:0] phase_ticks_r;

  dec_t dec, q_data;
  logic q_push, q_ready, q_valid, q_pop;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_addr_r   <= 6'd16;
      lead_ticks_r  <= 8'd1;
      phase_ticks_r <= 8'd2;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ADDR:  disp_addr_r   <= cfg_data[5:0];
        REG_LEAD:  lead_ticks_r  <= cfg_data;
        REG_PHASE: phase_ticks_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  slw_front #(
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .CLEAR_BITS   (CLEAR_BITS)
  ) u_front (
    .in_opcode        (in_opcode),
    .in_command_byte  (in_command_byte),
    .in_top_digits    (in_top_digits),
    .in_bottom_digits (in_bottom_digits),
    .in_decimal_points(in_decimal_points),
    .in_unit_marks    (in_unit_marks),
    .display_address  (disp_addr_r),
    .dec              (dec)
  );

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  slw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (dec),
    .push_ready(q_ready),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  slw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .lead_ticks (lead_ticks_r),
    .phase_ticks(phase_ticks_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  assign out_select_line = res.select_line;
  assign out_strobe_line = res.strobe_line;
  assign out_data_line   = res.data_line;
  assign out_busy_res    = res.busy;
  assign out_rejected    = res.rejected;
  assign out_frame_done  = res.frame_done;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for segment_lcd_serial_writer. Sends request and
// tick items, predicts the pin levels and flags of every item and checks each result.
// Depends on slw_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import slw_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [7:0]  cmd;
    logic [19:0] top;
    logic [19:0] bot;
    logic [1:0]  points;
    logic [1:0]  units;
  } lcd_item_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_EVERY_FOURTH,
    RDY_COIN
  } rdy_mode_t;

  // glyph of code i at bits [8i +: 8], codes 0..17
  localparam logic [143:0] TOP_GLYPHS = {
    8'h4C, 8'h26, 8'h6C, 8'h64, 8'h27, 8'h77, 8'h00, 8'h20, 8'h7B,
    8'h7F, 8'h51, 8'h6F, 8'h6B, 8'h72, 8'h79, 8'h3D, 8'h50, 8'h5F};
  localparam logic [143:0] BOT_GLYPHS = {
    8'h31, 8'h62, 8'h33, 8'h23, 8'hE2, 8'hE7, 8'h00, 8'h02, 8'hD7,
    8'hF7, 8'h85, 8'hF3, 8'hD3, 8'h47, 8'h97, 8'hB6, 8'h05, 8'hF5};
  localparam logic [4:0] BLANK_CODE = 5'd11;
  localparam logic [4:0] LAST_CODE  = 5'd17;

  localparam logic [8:0] SEG_PAYLOAD_BITS   = 9'd64;
  localparam logic [8:0] CLEAR_PAYLOAD_BITS = 9'd128;
  localparam int CMD_FRAME_BITS   = 12;
  localparam int WRITE_FRAME_BITS = 73;
  localparam int CLEAR_FRAME_BITS = 137;
  localparam int MAX_REPORTS      = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_opcode = OP_TICK;
  logic [7:0]  in_command_byte = '0;
  logic [19:0] in_top_digits = '0;
  logic [19:0] in_bottom_digits = '0;
  logic [1:0]  in_decimal_points = '0;
  logic [1:0]  in_unit_marks = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ADDR;
  logic [7:0]  cfg_data = '0;
  wire logic   in_ready, out_valid;
  wire logic   out_select_line, out_strobe_line, out_data_line;
  wire logic   out_busy_res, out_rejected, out_frame_done;

  segment_lcd_serial_writer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_command_byte   (in_command_byte),
    .in_top_digits     (in_top_digits),
    .in_bottom_digits  (in_bottom_digits),
    .in_decimal_points (in_decimal_points),
    .in_unit_marks     (in_unit_marks),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_select_line   (out_select_line),
    .out_strobe_line   (out_strobe_line),
    .out_data_line     (out_data_line),
    .out_busy_res      (out_busy_res),
    .out_rejected      (out_rejected),
    .out_frame_done    (out_frame_done),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  // Register copies and writer state as the block should hold them
  logic [5:0]       disp_addr = 6'd16;
  logic [7:0]       lead_cfg = 8'd1;
  logic [7:0]       phase_cfg = 8'd2;
  phase_t           seq_ph = PH_IDLE;
  logic [HDR_W-1:0] hdr_bits = '0;
  logic [3:0]       hdr_cnt = '0;
  logic [8:0]       pay_cnt = '0;
  logic [63:0]      seg_bits = '0;
  logic [7:0]       tick_cnt = '0;
  logic             pin_cs = 1'b1;
  logic             pin_wr = 1'b1;
  logic             pin_da = 1'b1;

  lcd_item_t pending_items[$];
  res_t      expected_levels[$];
  int        pushed_cnt = 0;
  int        taken_cnt = 0;
  int        checked_cnt = 0;
  int        err_cnt = 0;
  int        busy_left = 0;   // ticks until the frame being generated ends
  int        stage = 1;
  bit        hold_off = 1'b0;
  logic      in_taken = 1'b0;

  function automatic logic [7:0] glyph(logic [143:0] tbl, logic [19:0] digits, int pos);
    logic [4:0] code;
    int idx;
    code = digits[15-5*pos +: 5];
    if (code > LAST_CODE) code = BLANK_CODE;
    idx = int'(code);
    return tbl[idx*8 +: 8];
  endfunction

  // top row fills bytes 0..3, bottom row bytes 7..4
  function automatic logic [63:0] seg_image(lcd_item_t it);
    logic [7:0]  b [8];
    logic [63:0] img;
    for (int i = 0; i < 4; i++) begin
      b[i]   = glyph(TOP_GLYPHS, it.top, i);
      b[7-i] = glyph(BOT_GLYPHS, it.bot, i);
    end
    if (it.points[0]) b[2] |= TOP_POINT;
    if (it.points[1]) b[5] |= BOT_POINT;
    if (it.units[0]) b[3] |= UNIT_MARK;
    if (it.units[1]) b[1] |= UNIT_MARK;
    for (int k = 0; k < 8; k++) img[8*k +: 8] = b[k];
    return img;
  endfunction

  // a zero count ends the period on the first tick, same as one
  function automatic bit tick_elapsed();
    if (tick_cnt <= 8'd1) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = tick_cnt - 8'd1;
    return 1'b0;
  endfunction

  function automatic void shift_out_bit();
    logic b;
    if (hdr_cnt != 4'd0) begin
      b = hdr_bits[HDR_W-1];
      hdr_bits = {hdr_bits[HDR_W-2:0], 1'b0};
      hdr_cnt = hdr_cnt - 4'd1;
    end else begin
      b = seg_bits[0];
      seg_bits = seg_bits >> 1;
      if (pay_cnt != 9'd0) pay_cnt = pay_cnt - 9'd1;
    end
    pin_wr = 1'b0;
    pin_da = b;
    tick_cnt = phase_cfg;
    seq_ph = PH_LOW;
  endfunction

  function automatic res_t lcd_apply_item(lcd_item_t it);
    res_t r;
    logic rej, done;
    rej = 1'b0;
    done = 1'b0;
    if (it.op != OP_TICK) begin
      if (seq_ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        case (it.op)
          OP_CMD: begin
            hdr_bits = {ID_CMD, it.cmd, 1'b0};
            hdr_cnt = CMD_HDR_BITS;
            pay_cnt = '0;
            seg_bits = '0;
          end
          OP_WRITE: begin
            hdr_bits = {ID_WRITE, disp_addr, 3'b000};
            hdr_cnt = WRITE_HDR_BITS;
            pay_cnt = SEG_PAYLOAD_BITS;
            seg_bits = seg_image(it);
          end
          default: begin
            // clear: address zero, payload all zero
            hdr_bits = {ID_WRITE, 6'd0, 3'b000};
            hdr_cnt = WRITE_HDR_BITS;
            pay_cnt = CLEAR_PAYLOAD_BITS;
            seg_bits = '0;
          end
        endcase
        pin_cs = 1'b0;
        tick_cnt = lead_cfg;
        seq_ph = PH_LEAD;
      end
    end else begin
      case (seq_ph)
        PH_LEAD: if (tick_elapsed()) shift_out_bit();
        PH_LOW: if (tick_elapsed()) begin
          pin_wr = 1'b1;
          tick_cnt = phase_cfg;
          seq_ph = PH_HIGH;
        end
        PH_HIGH: if (tick_elapsed()) begin
          if (hdr_cnt != 4'd0 || pay_cnt != 9'd0) begin
            shift_out_bit();
          end else begin
            pin_cs = 1'b1;
            tick_cnt = lead_cfg;
            seq_ph = PH_TAIL;
          end
        end
        PH_TAIL: if (tick_elapsed()) begin
          pin_da = 1'b1;
          seq_ph = PH_IDLE;
          done = 1'b1;
        end
        default: ;
      endcase
    end
    r.select_line = pin_cs;
    r.strobe_line = pin_wr;
    r.data_line   = pin_da;
    r.busy        = (seq_ph != PH_IDLE);
    r.rejected    = rej;
    r.frame_done  = done;
    return r;
  endfunction

  // ---------------- stimulus generation ----------------
  function automatic int frame_ticks(op_t op);
    int l, p, nb;
    l = (lead_cfg == 8'd0) ? 1 : int'(lead_cfg);
    p = (phase_cfg == 8'd0) ? 1 : int'(phase_cfg);
    nb = (op == OP_CMD) ? CMD_FRAME_BITS : (op == OP_WRITE) ? WRITE_FRAME_BITS
                                                            : CLEAR_FRAME_BITS;
    return 2*l + 2*p*nb;
  endfunction

  task automatic queue_item(input op_t op, input logic [7:0] cmd,
                            input logic [19:0] top, bot, input logic [1:0] points, units);
    lcd_item_t it;
    it = '{op: op, cmd: cmd, top: top, bot: bot, points: points, units: units};
    pending_items.push_back(it);
    pushed_cnt++;
    if (op != OP_TICK) begin
      if (busy_left == 0) busy_left = frame_ticks(op);
    end else if (busy_left > 0) begin
      busy_left--;
    end
  endtask

  task automatic queue_tick();
    queue_item(OP_TICK, 8'($urandom), 20'($urandom), 20'($urandom), 2'($urandom),
               2'($urandom));
  endtask

  task automatic finish_frame();
    while (busy_left > 0) queue_tick();
  endtask

  // mostly valid glyph codes, sometimes out-of-range codes or raw bits
  function automatic logic [19:0] rand_digits();
    logic [19:0] d;
    if ($urandom_range(0, 3) == 0) return 20'($urandom);
    for (int i = 0; i < 4; i++)
      d[5*i +: 5] = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(18, 31)
                                                    : $urandom_range(0, 17));
    return d;
  endfunction

  task automatic random_items(int n);
    int  r;
    op_t op;
    repeat (n) begin
      r = $urandom_range(0, 23);
      if ((busy_left == 0 && r < 14) || (busy_left != 0 && r == 0)) begin
        r = $urandom_range(0, 9);
        op = (r < 5) ? OP_CMD : (r < 8) ? OP_WRITE : OP_CLEAR;
        queue_item(op, 8'($urandom), rand_digits(), rand_digits(), 2'($urandom),
                   2'($urandom));
      end else begin
        queue_tick();
      end
    end
    finish_frame();
  endtask

  task automatic wait_drained();
    while (taken_cnt != pushed_cnt || checked_cnt != taken_cnt) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ADDR: disp_addr = val[5:0];
      REG_LEAD: lead_cfg = val;
      default:  phase_cfg = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(input logic [7:0] addr, lead, ph);
    wait_drained();
    write_reg(REG_ADDR, addr);
    write_reg(REG_LEAD, lead);
    write_reg(REG_PHASE, ph);
    stage++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings
    queue_item(OP_TICK, 8'hFF, 20'hFFFFF, 20'hFFFFF, 2'b11, 2'b11);
    queue_item(OP_CMD, 8'h00, '0, '0, '0, '0);
    queue_item(OP_WRITE, 8'h00, '0, '0, '0, '0);
    queue_item(OP_CLEAR, 8'h00, '0, '0, '0, '0);
    queue_item(OP_CMD, 8'hFF, '0, '0, '0, '0);
    finish_frame();
    queue_item(OP_TICK, 8'h00, '0, '0, '0, '0);

    reconfigure(8'd0, 8'd1, 8'd1);
    random_items(80);
    // address field is six bits, upper data bits drop
    reconfigure(8'hFF, 8'd3, 8'd1);
    random_items(50);
    // zero tick counts behave as one
    reconfigure(8'd42, 8'd0, 8'd0);
    random_items(50);
    reconfigure(8'hC5, 8'd9, 8'd1);
    queue_item(OP_WRITE, 8'h3C, {5'd10, 5'd12, 5'd13, 5'd31}, {5'd14, 5'd15, 5'd16, 5'd17},
               2'b01, 2'b10);
    finish_frame();
    reconfigure(8'd63, 8'd1, 8'd3);
    queue_item(OP_CMD, 8'h5A, '0, '0, '0, '0);
    queue_item(OP_CLEAR, 8'h00, '0, '0, '0, '0);
    finish_frame();

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && expected_levels.size() == 0)
      $display("[segment_lcd_serial_writer] OK");
    else
      $display("[segment_lcd_serial_writer] ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("[segment_lcd_serial_writer] ERROR");
    $finish;
  end

  // long receiver hold-off early in the first random phase: the block backs up
  initial begin
    int mark;
    while (stage < 2) @(posedge clk);
    mark = taken_cnt;
    while (taken_cnt < mark + 40) @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // ---------------- sender ----------------
  int gap_left = 0;
  int burst_left = 1;

  always @(negedge clk) begin : send_items
    lcd_item_t cur;
    if (!rst_n || (in_valid && !in_taken)) begin
      // hold the offered item until taken
    end else if (gap_left != 0 || pending_items.size() == 0) begin
      in_valid <= 1'b0;
      if (gap_left != 0) gap_left--;
    end else begin
      cur = pending_items.pop_front();
      in_valid <= 1'b1;
      in_opcode <= cur.op;
      in_command_byte <= cur.cmd;
      in_top_digits <= cur.top;
      in_bottom_digits <= cur.bot;
      in_decimal_points <= cur.points;
      in_unit_marks <= cur.units;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  end

  // ---------------- receiver ----------------
  rdy_mode_t rdy_mode = RDY_ALWAYS;
  int        rdy_left = 0;
  int        rdy_phase = 0;

  always @(negedge clk) begin : accept_results
    if (rdy_left == 0) begin
      rdy_mode = rdy_mode_t'($urandom_range(0, 3));
      rdy_left = $urandom_range(16, 96);
    end else begin
      rdy_left--;
    end
    rdy_phase++;
    case (rdy_mode)
      RDY_ALWAYS:       out_ready <= !hold_off;
      RDY_MOSTLY:       out_ready <= !hold_off && ($urandom_range(0, 3) != 0);
      RDY_EVERY_FOURTH: out_ready <= !hold_off && (rdy_phase % 4 != 3);
      default:          out_ready <= !hold_off && ($urandom_range(0, 1) != 0);
    endcase
  end

  // ---------------- prediction and checking ----------------
  always @(posedge clk) begin : check_results
    res_t      got, want;
    lcd_item_t it;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.select_line = out_select_line;
        got.strobe_line = out_strobe_line;
        got.data_line   = out_data_line;
        got.busy        = out_busy_res;
        got.rejected    = out_rejected;
        got.frame_done  = out_frame_done;
        if (expected_levels.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result with no item pending, cs/wr/da/busy/rej/done=%b",
                     $realtime, got);
        end else begin
          want = expected_levels.pop_front();
          checked_cnt++;
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: result %0d cs/wr/da/busy/rej/done expected %b got %b",
                       $realtime, checked_cnt, want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        it.op     = op_t'(in_opcode);
        it.cmd    = in_command_byte;
        it.top    = in_top_digits;
        it.bot    = in_bottom_digits;
        it.points = in_decimal_points;
        it.units  = in_unit_marks;
        expected_levels.push_back(lcd_apply_item(it));
        taken_cnt++;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/slw_pkg.sv
rtl/slw_front.sv
rtl/slw_queue.sv
rtl/slw_back.sv
rtl/segment_lcd_serial_writer.sv
dv/tb_top.sv
